FILE: rtl/core/modbus_ascii_frame_receiver_defines.svh
// ---------------------------------------------------------------------------
// Modbus ASCII frame receiver assertion macros
// Shared concurrent assertion forms, clocked on clock and quiet in reset.
// ---------------------------------------------------------------------------
`ifndef MODBUS_ASCII_FRAME_RECEIVER_DEFINES_SVH
`define MODBUS_ASCII_FRAME_RECEIVER_DEFINES_SVH

// Check cons in the same cycle as ante
`define MAFR_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante
`define MAFR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/mafr_pkg.sv
// ---------------------------------------------------------------------------
// Modbus ASCII frame receiver package
// Phase type, action and status codes, character codes and hex decode.
// ---------------------------------------------------------------------------
package mafr_pkg;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_HIGH = 2'd1,
      PH_LOW  = 2'd2,
      PH_LF   = 2'd3
   } phase_type;

   localparam logic [1:0] ACT_ARM  = 2'd0;
   localparam logic [1:0] ACT_CHAR = 2'd1;
   localparam logic [1:0] ACT_TICK = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_TIMEOUT  = 2'd1;
   localparam logic [1:0] ST_BADMSG   = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   localparam logic       KIND_DATA = 1'b0;
   localparam logic       KIND_END  = 1'b1;

   localparam logic       CSR_CHAR_TIMEOUT = 1'b0;
   localparam logic       CSR_RESP_TIMEOUT = 1'b1;

   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] HEX_ALPHA_OFFSET = 8'd10;

   typedef struct packed {
      logic       ok;
      logic [3:0] nibble;
   } hex_type;

   // Decode one ASCII hex digit, either case
   function automatic hex_type hex_decode(input logic [7:0] ch);
      hex_type    res;
      logic [7:0] v;
      res = '0;
      v   = '0;
      if (ch >= "0" && ch <= "9") begin
         v = ch - 8'("0");
         res.ok = 1'b1;
      end else if (ch >= "A" && ch <= "F") begin
         v = ch - 8'("A") + HEX_ALPHA_OFFSET;
         res.ok = 1'b1;
      end else if (ch >= "a" && ch <= "f") begin
         v = ch - 8'("a") + HEX_ALPHA_OFFSET;
         res.ok = 1'b1;
      end
      res.nibble = v[3:0];
      return res;
   endfunction

endpackage

FILE: rtl/core/modbus_ascii_frame_receiver.sv
// ---------------------------------------------------------------------------
// Modbus ASCII frame receiver
// Hunts for ':', decodes hex pairs into bytes, checks CR LF, length and LRC, and times out.
// ---------------------------------------------------------------------------
// The block takes one transaction per clock cycle: arm, received character
// or timer tick. Each transaction updates the frame state in a single
// registered pass and yields at most one result, held in the output
// register from the cycle after acceptance. req_ready drops only while a result
// sits in that register and rsp_ready is low, so the sustained rate is one
// transaction per cycle whenever the result side keeps up. No clearing pass
// follows reset. Timeouts are counted in tick transactions; a timeout
// register of zero disables that timeout.
`include "modbus_ascii_frame_receiver_defines.svh"

module modbus_ascii_frame_receiver
   import mafr_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 256,
   parameter int MIN_FRAME_BYTES = 3
) (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [23:0] csr_wdata,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_character,
   input  logic        req_wait_response,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [7:0]  rsp_byte_index,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_unit_address,
   output logic [7:0]  rsp_pdu_length
);

   localparam int CNT_TOP = (MAX_FRAME_BYTES > MIN_FRAME_BYTES) ?
                            MAX_FRAME_BYTES : MIN_FRAME_BYTES;
   localparam int CNT_W   = $clog2(CNT_TOP + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);
   localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_FRAME_BYTES);
   localparam logic [CNT_W-1:0] CNT_ADDR_LRC = CNT_W'(2);

   // configuration registers
   logic [23:0]      char_to_ff, resp_to_ff;

   // frame state
   phase_type        phase_ff, phase_in;
   logic             start_to_ff, start_to_in;
   logic [3:0]       nib_ff, nib_in;
   logic             bad_high_ff, bad_high_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       lrc_ff, lrc_in;
   logic [7:0]       addr_ff, addr_in;
   logic [23:0]      idle_ff, idle_in;

   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_kind_ff, rsp_kind_in;
   logic [7:0]       rsp_data_ff, rsp_data_in;
   logic [7:0]       rsp_index_ff, rsp_index_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [7:0]       rsp_addr_ff, rsp_addr_in;
   logic [7:0]       rsp_pdu_ff, rsp_pdu_in;

   // decode events
   logic             req_fire;
   logic             fin, emit, colon_hit, take_high, tick_inc;
   logic [1:0]       fin_status;
   logic [23:0]      limit, idle_inc;
   hex_type          hex;
   logic [7:0]       byte_val;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign hex       = hex_decode(req_character);
   assign idle_inc  = idle_ff + 24'd1;
   assign byte_val  = {nib_ff, hex.nibble};
   assign limit     = (phase_ff == PH_HUNT) ? (start_to_ff ? resp_to_ff : 24'd0)
                                            : char_to_ff;

   // next phase and frame events
   always_comb begin
      phase_in   = phase_ff;
      fin        = 1'b0;
      fin_status = ST_OK;
      emit       = 1'b0;
      colon_hit  = 1'b0;
      take_high  = 1'b0;
      tick_inc   = 1'b0;
      case (req_action)
         ACT_ARM: begin
            phase_in = PH_HUNT;
         end
         ACT_TICK: begin
            if (limit != 24'd0) begin
               tick_inc = 1'b1;
               if (idle_inc >= limit) begin
                  fin        = 1'b1;
                  fin_status = ST_TIMEOUT;
               end
            end
         end
         ACT_CHAR: begin
            case (phase_ff)
               PH_HUNT: begin
                  if (req_character == CH_COLON) begin
                     colon_hit = 1'b1;
                     phase_in  = PH_HIGH;
                  end
               end
               PH_HIGH: begin
                  if (req_character == CH_CR) begin
                     phase_in = PH_LF;
                  end else if (cnt_ff >= CNT_MAX) begin
                     fin        = 1'b1;
                     fin_status = ST_OVERFLOW;
                  end else begin
                     take_high = 1'b1;
                     phase_in  = PH_LOW;
                  end
               end
               PH_LOW: begin
                  if (bad_high_ff || !hex.ok) begin
                     fin        = 1'b1;
                     fin_status = ST_BADMSG;
                  end else begin
                     emit     = 1'b1;
                     phase_in = PH_HIGH;
                  end
               end
               default: begin
                  fin = 1'b1;
                  if (req_character != CH_LF || cnt_ff < CNT_MIN || lrc_ff != 8'd0) begin
                     fin_status = ST_BADMSG;
                  end
               end
            endcase
         end
         default: begin
         end
      endcase
      if (fin) begin
         phase_in = PH_HUNT;
      end
   end

   // frame datapath and result fields
   always_comb begin
      start_to_in   = start_to_ff;
      nib_in        = nib_ff;
      bad_high_in   = bad_high_ff;
      cnt_in        = cnt_ff;
      lrc_in        = lrc_ff;
      addr_in       = addr_ff;
      idle_in       = idle_ff;
      rsp_kind_in   = KIND_DATA;
      rsp_data_in   = '0;
      rsp_index_in  = '0;
      rsp_status_in = ST_OK;
      rsp_addr_in   = '0;
      rsp_pdu_in    = '0;
      if (req_action == ACT_CHAR) begin
         idle_in = '0;
      end
      if (tick_inc) begin
         idle_in = idle_inc;
      end
      if (take_high) begin
         bad_high_in = !hex.ok;
         nib_in      = hex.ok ? hex.nibble : 4'd0;
      end
      if (emit) begin
         rsp_data_in  = byte_val;
         rsp_index_in = 8'(cnt_ff);
         if (cnt_ff == '0) begin
            addr_in = byte_val;
         end
         lrc_in = lrc_ff + byte_val;
         cnt_in = cnt_ff + CNT_W'(1);
         nib_in = '0;
      end
      if (fin) begin
         rsp_kind_in   = KIND_END;
         rsp_status_in = fin_status;
         if (fin_status == ST_OK) begin
            rsp_addr_in = addr_ff;
            rsp_pdu_in  = 8'(cnt_ff - CNT_ADDR_LRC);
         end
         start_to_in = 1'b0;
      end
      if (req_action == ACT_ARM) begin
         start_to_in = req_wait_response;
      end
      // clear the frame on arm, on start character and after an end result
      if (req_action == ACT_ARM || colon_hit || fin) begin
         nib_in      = '0;
         bad_high_in = 1'b0;
         cnt_in      = '0;
         lrc_in      = '0;
         addr_in     = '0;
         idle_in     = '0;
      end
   end

   // hold a result until taken, load a new one on a producing transaction
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire && (fin || emit)) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         char_to_ff   <= '0;
         resp_to_ff   <= '0;
         phase_ff     <= PH_HUNT;
         start_to_ff  <= 1'b0;
         nib_ff       <= '0;
         bad_high_ff  <= 1'b0;
         cnt_ff       <= '0;
         lrc_ff       <= '0;
         addr_ff      <= '0;
         idle_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_CHAR_TIMEOUT) begin
               char_to_ff <= csr_wdata;
            end else begin
               resp_to_ff <= csr_wdata;
            end
         end
         if (req_fire) begin
            phase_ff    <= phase_in;
            start_to_ff <= start_to_in;
            nib_ff      <= nib_in;
            bad_high_ff <= bad_high_in;
            cnt_ff      <= cnt_in;
            lrc_ff      <= lrc_in;
            addr_ff     <= addr_in;
            idle_ff     <= idle_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_fire && (fin || emit)) begin
         rsp_kind_ff   <= rsp_kind_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_index_ff  <= rsp_index_in;
         rsp_status_ff <= rsp_status_in;
         rsp_addr_ff   <= rsp_addr_in;
         rsp_pdu_ff    <= rsp_pdu_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_data_byte    = rsp_data_ff;
   assign rsp_byte_index   = rsp_index_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_unit_address = rsp_addr_ff;
   assign rsp_pdu_length   = rsp_pdu_ff;

   // assertions
   `MAFR_ASSERT_SAME(a_ready_stall, !req_ready, rsp_valid_ff && !rsp_ready,
      "request stalled without a waiting result")
   `MAFR_ASSERT_SAME(a_count_bound, 1'b1, cnt_ff <= CNT_MAX,
      "byte count beyond frame limit")
   `MAFR_ASSERT_NEXT(a_end_hunts, req_fire && fin,
      phase_ff == PH_HUNT && !start_to_ff && cnt_ff == '0,
      "frame state not cleared after end result")
   `MAFR_ASSERT_SAME(a_err_fields,
      rsp_valid_ff && (rsp_kind_ff == KIND_DATA || rsp_status_ff != ST_OK),
      rsp_addr_ff == 8'd0 && rsp_pdu_ff == 8'd0,
      "address or length set on a non-ok result")

endmodule

FILE: dv/modbus_ascii_frame_receiver_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Modbus ASCII frame receiver testbench
// Drives arm, character and tick transactions through the request channel,
// predicts every data byte and end-of-frame result with a cycle-free model
// of the receiver, and checks each response field by field in order.
// ---------------------------------------------------------------------------
module modbus_ascii_frame_receiver_tb;
   import mafr_pkg::*;

   localparam logic [1:0]  ACT_UNUSED = 2'd3;
   localparam int          MAX_BYTES  = 256;
   localparam int          MIN_BYTES  = 3;
   localparam logic [23:0] TICKS_MAX  = 24'hFFFFFF;
   localparam int          HOLD_CYCLES = 200;
   localparam int          CYCLE_LIMIT = 400000;
   localparam int          PHASE_ITEMS = 100;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic [7:0] byte_index;
      logic [1:0] status;
      logic [7:0] unit_address;
      logic [7:0] pdu_length;
   } rx_result_type;

   typedef struct packed {
      logic [1:0]    act;
      logic [7:0]    ch;
      logic          wr;
      bit            typed;
      bit            has;
      rx_result_type res;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [23:0] csr_wdata;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_action;
   logic [7:0]  req_character;
   logic        req_wait_response;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [7:0]  rsp_byte_index;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_unit_address;
   logic [7:0]  rsp_pdu_length;

   // receiver model state and its copy of the timeout registers
   phase_type   mdl_phase = PH_HUNT;
   bit          mdl_resp_armed = 1'b0;
   logic [3:0]  mdl_high_nibble = '0;
   bit          mdl_high_bad = 1'b0;
   logic [8:0]  mdl_byte_count = '0;
   logic [7:0]  mdl_lrc = '0;
   logic [7:0]  mdl_address = '0;
   logic [23:0] mdl_idle_ticks = '0;
   logic [23:0] mdl_char_timeout = '0;
   logic [23:0] mdl_resp_timeout = '0;

   rx_result_type pending_results[$];
   int          error_count = 0;
   int          sent_items = 0;
   int          cycle_count = 0;
   bit          quiet = 1'b0;
   bit          hold_req = 1'b0;
   bit          hold_taken = 1'b0;
   int          hold_left = 0;

   // directed frames: clean frame with both extremes, bad hex, missing LF,
   // short frame, response timeout, character timeout over a bad high digit
   dir_row_type dir_rows [29] = '{
      '{ACT_TICK,   8'h00,    1'b0, 1'b1, 1'b0, '0},
      '{ACT_UNUSED, 8'h3A,    1'b1, 1'b1, 1'b0, '0},
      '{ACT_CHAR,   8'hFF,    1'b0, 1'b0, 1'b0, '0},
      '{ACT_CHAR,   CH_COLON, 1'b0, 1'b0, 1'b0, '0},
      '{ACT_CHAR,   "0",      1'b0, 1'b0, 1'b0, '0},
      '{ACT_CHAR,   "1",      1'b0, 1'b1, 1'b1,
        '{KIND_DATA, 8'h01, 8'd0, ST_OK, 8'h00, 8'h00}},
      '{ACT_CHAR,   "f",      1'b0, 1'b0, 1'b0, '0},
      '{ACT_CHAR,   "F",      1'b0, 1'b1, 1'b1,
        '{KIND_DATA, 8'hFF, 8'd1, ST_OK, 8'h00, 8'h00}},
      '{ACT_CHAR,   "0",      1'b0, 1'b0, 1'b0, '0},
      '{ACT_CHAR,   "0",      1'b0, 1'b1, 1'b1,
        '{KIND_DATA, 8'h00, 8'd2, ST_OK, 8'h00, 8'h00}},
      '{ACT_CHAR,   CH_CR,    1'b0, 1'b0, 1'b0, '0},
      '{ACT_CHAR,   CH_LF,    1'b0, 1'b1, 1'b1,
        '{KIND_END, 8'h00, 8'd0, ST_OK, 8'h01, 8'h01}},
      '{ACT_CHAR,   CH_COLON, 1'b0, 1'b0, 1'b0, '0},
      '{ACT_CHAR,   "G",      1'b0, 1'b0, 1'b0, '0},
      '{ACT_CHAR,   "0",      1'b0, 1'b1, 1'b1,
        '{KIND_END, 8'h00, 8'd0, ST_BADMSG, 8'h00, 8'h00}},
      '{ACT_CHAR,   CH_COLON, 1'b0, 1'b0, 1'b0, '0},
      '{ACT_CHAR,   CH_CR,    1'b0, 1'b0, 1'b0, '0},
      '{ACT_CHAR,   "X",      1'b0, 1'b1, 1'b1,
        '{KIND_END, 8'h00, 8'd0, ST_BADMSG, 8'h00, 8'h00}},
      '{ACT_CHAR,   CH_COLON, 1'b0, 1'b0, 1'b0, '0},
      '{ACT_CHAR,   CH_CR,    1'b0, 1'b0, 1'b0, '0},
      '{ACT_CHAR,   CH_LF,    1'b0, 1'b1, 1'b1,
        '{KIND_END, 8'h00, 8'd0, ST_BADMSG, 8'h00, 8'h00}},
      '{ACT_ARM,    8'h00,    1'b1, 1'b1, 1'b0, '0},
      '{ACT_TICK,   8'h00,    1'b0, 1'b0, 1'b0, '0},
      '{ACT_TICK,   8'h00,    1'b0, 1'b0, 1'b0, '0},
      '{ACT_TICK,   8'h00,    1'b0, 1'b1, 1'b1,
        '{KIND_END, 8'h00, 8'd0, ST_TIMEOUT, 8'h00, 8'h00}},
      '{ACT_CHAR,   CH_COLON, 1'b0, 1'b0, 1'b0, '0},
      '{ACT_CHAR,   "g",      1'b0, 1'b0, 1'b0, '0},
      '{ACT_TICK,   8'h00,    1'b0, 1'b0, 1'b0, '0},
      '{ACT_TICK,   8'h00,    1'b0, 1'b1, 1'b1,
        '{KIND_END, 8'h00, 8'd0, ST_TIMEOUT, 8'h00, 8'h00}}
   };

   modbus_ascii_frame_receiver u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_character     (req_character),
      .req_wait_response (req_wait_response),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_status        (rsp_status),
      .rsp_unit_address  (rsp_unit_address),
      .rsp_pdu_length    (rsp_pdu_length)
   );

   // 20 ns clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Value of one ASCII hex digit, -1 when the character is not hex
   function automatic int digit_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      return -1;
   endfunction

   // Encode one nibble as a hex digit, letters in random case
   function automatic logic [7:0] digit_char(input logic [3:0] n);
      if (n < 4'd10) return 8'("0") + 8'(n);
      if ($urandom_range(1) == 0) return 8'("A") + 8'(n) - 8'd10;
      return 8'("a") + 8'(n) - 8'd10;
   endfunction

   // Clear the per-frame counters
   function automatic void clear_frame_state();
      mdl_high_nibble = '0;
      mdl_high_bad    = 1'b0;
      mdl_byte_count  = '0;
      mdl_lrc         = '0;
      mdl_address     = '0;
      mdl_idle_ticks  = '0;
   endfunction

   // Build the end-of-frame result and return to the hunt
   function automatic bit close_frame(input logic [1:0] st, output rx_result_type r);
      r = '0;
      r.kind   = KIND_END;
      r.status = st;
      if (st == ST_OK) begin
         r.unit_address = mdl_address;
         r.pdu_length   = 8'(mdl_byte_count - 9'd2);
      end
      mdl_phase      = PH_HUNT;
      mdl_resp_armed = 1'b0;
      clear_frame_state();
      return 1'b1;
   endfunction

   // Advance the receiver model by one transaction; return 1 with a result
   function automatic bit predict_rx_step(input logic [1:0] act, input logic [7:0] ch,
                                          input logic wr, output rx_result_type r);
      logic [23:0] limit;
      int          lo;
      logic [7:0]  b;
      r = '0;
      case (act)
         ACT_ARM: begin
            mdl_phase      = PH_HUNT;
            mdl_resp_armed = wr;
            clear_frame_state();
            return 1'b0;
         end
         ACT_TICK: begin
            if (mdl_phase == PH_HUNT) limit = mdl_resp_armed ? mdl_resp_timeout : '0;
            else limit = mdl_char_timeout;
            if (limit == '0) return 1'b0;
            mdl_idle_ticks = mdl_idle_ticks + 24'd1;
            if (mdl_idle_ticks >= limit) return close_frame(ST_TIMEOUT, r);
            return 1'b0;
         end
         ACT_CHAR: begin
            mdl_idle_ticks = '0;
            case (mdl_phase)
               PH_HUNT: begin
                  if (ch == CH_COLON) begin
                     clear_frame_state();
                     mdl_phase = PH_HIGH;
                  end
                  return 1'b0;
               end
               PH_HIGH: begin
                  if (ch == CH_CR) begin
                     mdl_phase = PH_LF;
                     return 1'b0;
                  end
                  if (int'(mdl_byte_count) >= MAX_BYTES) return close_frame(ST_OVERFLOW, r);
                  lo = digit_value(ch);
                  mdl_high_bad    = (lo < 0);
                  mdl_high_nibble = (lo < 0) ? 4'd0 : 4'(lo);
                  mdl_phase       = PH_LOW;
                  return 1'b0;
               end
               PH_LOW: begin
                  lo = digit_value(ch);
                  if (mdl_high_bad || lo < 0) return close_frame(ST_BADMSG, r);
                  b = {mdl_high_nibble, 4'(lo)};
                  r.kind       = KIND_DATA;
                  r.data_byte  = b;
                  r.byte_index = 8'(mdl_byte_count);
                  if (mdl_byte_count == '0) mdl_address = b;
                  mdl_lrc         = mdl_lrc + b;
                  mdl_byte_count  = mdl_byte_count + 9'd1;
                  mdl_high_nibble = '0;
                  mdl_phase       = PH_HIGH;
                  return 1'b1;
               end
               default: begin
                  if (ch != CH_LF) return close_frame(ST_BADMSG, r);
                  if (int'(mdl_byte_count) < MIN_BYTES) return close_frame(ST_BADMSG, r);
                  if (mdl_lrc != '0) return close_frame(ST_BADMSG, r);
                  return close_frame(ST_OK, r);
               end
            endcase
         end
         default: return 1'b0;
      endcase
   endfunction

   // Offer one transaction, wait for acceptance, then record the expected result
   task automatic send_item(input logic [1:0] act, input logic [7:0] ch, input logic wr,
                            input bit typed, input bit t_has, input rx_result_type t_res);
      bit            has;
      rx_result_type r;
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 7) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid         = 1'b1;
      req_action        = act;
      req_character     = ch;
      req_wait_response = wr;
      do @(posedge clock); while (!req_ready);
      has = predict_rx_step(act, ch, wr, r);
      if (typed) begin
         has = t_has;
         r   = t_res;
      end
      if (has) pending_results.push_back(r);
      if (act != ACT_UNUSED) sent_items++;
   endtask

   task automatic offer(input logic [1:0] act, input logic [7:0] ch, input logic wr);
      send_item(act, ch, wr, 1'b0, 1'b0, '0);
   endtask

   // Drop valid, wait for every expected result, then let the pipe settle
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [23:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_CHAR_TIMEOUT) mdl_char_timeout = val;
      else mdl_resp_timeout = val;
   endtask

   task automatic configure(input logic [23:0] char_ticks, input logic [23:0] resp_ticks);
      write_csr(CSR_CHAR_TIMEOUT, char_ticks);
      write_csr(CSR_RESP_TIMEOUT, resp_ticks);
   endtask

   // Sprinkle ticks inside a frame, now and then enough to hit the char timeout
   task automatic stray_ticks();
      int k;
      if ($urandom_range(7) == 0) begin
         k = $urandom_range(1, 3);
         if ($urandom_range(5) == 0 && mdl_char_timeout != '0 && mdl_char_timeout <= 24'd24)
            k = int'(mdl_char_timeout);
         repeat (k) offer(ACT_TICK, 8'($urandom), 1'($urandom));
      end
   endtask

   // Send one frame of nb bytes; a clean frame has no noise, ticks or bad digits
   task automatic send_frame(input int nb, input bit lrc_ok, input bit lf_ok, input bit clean);
      logic [7:0] sum;
      logic [7:0] b;
      logic [7:0] c;
      sum = '0;
      if (!clean && $urandom_range(3) == 0) offer(ACT_ARM, 8'($urandom), 1'($urandom));
      if (!clean) begin
         repeat ($urandom_range(2)) offer(ACT_CHAR, 8'($urandom), 1'($urandom));
         stray_ticks();
      end
      offer(ACT_CHAR, CH_COLON, 1'b0);
      for (int i = 0; i < nb; i++) begin
         b = 8'($urandom);
         if (i == nb - 1 && lrc_ok) b = 8'd0 - sum;
         sum = sum + b;
         c = digit_char(b[7:4]);
         if (!clean && $urandom_range(59) == 0) c = 8'($urandom);
         offer(ACT_CHAR, c, 1'($urandom));
         if (!clean) stray_ticks();
         c = digit_char(b[3:0]);
         if (!clean && $urandom_range(59) == 0) c = 8'($urandom);
         offer(ACT_CHAR, c, 1'($urandom));
      end
      offer(ACT_CHAR, CH_CR, 1'b0);
      c = CH_LF;
      if (!lf_ok) begin
         c = 8'($urandom);
         if (c == CH_LF) c = "X";
      end
      offer(ACT_CHAR, c, 1'b0);
   endtask

   // Mostly well-formed frames with random content, the rest raw noise
   task automatic run_phase(input int target);
      int start;
      int nb;
      start = sent_items;
      while (sent_items - start < target) begin
         if ($urandom_range(99) < 75) begin
            nb = ($urandom_range(9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 6);
            send_frame(nb, $urandom_range(9) != 0, $urandom_range(14) != 0, 1'b0);
         end else begin
            repeat ($urandom_range(1, 4)) offer(2'($urandom), 8'($urandom), 1'($urandom));
         end
      end
   endtask

   // Response side: random stalls, or a long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left != 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES - 1;
            rsp_ready  = 1'b0;
         end else begin
            rsp_ready = quiet || ($urandom_range(99) >= 7);
         end
      end
   end

   task automatic check_field(input string fname, input logic [7:0] exp_v,
                              input logic [7:0] got_v);
      if (got_v !== exp_v) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, exp_v, got_v);
      end
   endtask

   // Compare each response transaction with the oldest expected result
   always @(posedge clock) begin : rsp_check
      rx_result_type e;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, got kind %0h status %0h",
                     $time, rsp_kind, rsp_status);
         end else begin
            e = pending_results.pop_front();
            check_field("kind", 8'(e.kind), 8'(rsp_kind));
            check_field("data_byte", e.data_byte, rsp_data_byte);
            check_field("byte_index", e.byte_index, rsp_byte_index);
            check_field("status", 8'(e.status), 8'(rsp_status));
            check_field("unit_address", e.unit_address, rsp_unit_address);
            check_field("pdu_length", e.pdu_length, rsp_pdu_length);
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Stimulus sequence
   initial begin
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = 1'b0;
      csr_wdata         = '0;
      req_valid         = 1'b0;
      req_action        = ACT_ARM;
      req_character     = '0;
      req_wait_response = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      configure(24'd2, 24'd3);
      foreach (dir_rows[i])
         send_item(dir_rows[i].act, dir_rows[i].ch, dir_rows[i].wr,
                   dir_rows[i].typed, dir_rows[i].has, dir_rows[i].res);
      drain();

      // timeouts off, no idling on either side
      quiet = 1'b1;
      configure(24'd0, 24'd0);
      run_phase(PHASE_ITEMS);
      drain();
      quiet = 1'b0;

      configure(24'd1, 24'd1);
      run_phase(PHASE_ITEMS);
      drain();

      // hold off the response side so the request side backs up
      configure(24'd5, 24'd4);
      hold_req = 1'b1;
      run_phase(PHASE_ITEMS);
      drain();

      // longest legal frame, then one byte past the frame limit
      configure(TICKS_MAX, TICKS_MAX);
      send_frame(MAX_BYTES, 1'b1, 1'b1, 1'b1);
      send_frame(MAX_BYTES + 1, 1'b1, 1'b1, 1'b1);
      run_phase(PHASE_ITEMS / 2);
      drain();

      configure(24'($urandom_range(2, 12)), 24'($urandom_range(1, 12)));
      run_phase(PHASE_ITEMS);
      drain();

      configure(24'd3, 24'd0);
      run_phase(PHASE_ITEMS);
      drain();

      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/mafr_pkg.sv
rtl/core/modbus_ascii_frame_receiver.sv
dv/modbus_ascii_frame_receiver_tb.sv
